// ----- sv/phd_pkg.sv -----
// Shared types and constants for the pH dosing controller.
`timescale 1ns / 1ps

package phd_pkg;

    // Command codes carried by an input transaction
    localparam logic [2:0] CMD_EVAL       = 3'd0;
    localparam logic [2:0] CMD_TOGGLE_UP  = 3'd1;
    localparam logic [2:0] CMD_TOGGLE_DN  = 3'd2;
    localparam logic [2:0] CMD_STOP       = 3'd3;
    localparam logic [2:0] CMD_AUTO_ON    = 3'd4;
    localparam logic [2:0] CMD_AUTO_OFF   = 3'd5;

    // pH condition codes
    localparam logic [1:0] COND_IN_RANGE  = 2'd0;
    localparam logic [1:0] COND_TOO_HIGH  = 2'd1;
    localparam logic [1:0] COND_TOO_LOW   = 2'd2;

    // Register map: register index sits in paddr[4:2]
    localparam int unsigned ADDR_W = 5;
    localparam logic [2:0] REG_TARGET   = 3'd0;
    localparam logic [2:0] REG_TOL      = 3'd1;
    localparam logic [2:0] REG_DEADBAND = 3'd2;
    localparam logic [2:0] REG_DOSE     = 3'd3;
    localparam logic [2:0] REG_COOLDOWN = 3'd4;

    // Field widths
    localparam int unsigned PH_W = 11;
    localparam int unsigned MS_W = 22;

    // Register reset values
    localparam logic [PH_W-1:0] TARGET_RST   = 11'd600;
    localparam logic [PH_W-1:0] TOL_RST      = 11'd50;
    localparam logic [PH_W-1:0] DEADBAND_RST = 11'd20;
    localparam logic [MS_W-1:0] DOSE_RST     = 22'd10000;
    localparam logic [MS_W-1:0] COOLDOWN_RST = 22'd60000;

    // Largest valid pH sample (hundredths)
    localparam logic [PH_W-1:0] PH_VALID_MAX = 11'd1400;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [PH_W-1:0] target_ph;
        logic [PH_W-1:0] tolerance;
        logic [PH_W-1:0] deadband;
        logic [MS_W-1:0] dose_time_ms;
        logic [MS_W-1:0] cooldown_ms;
    } t_cfg;

endpackage

// ----- sv/ph_dosing_controller.sv -----
// Top level of the two-pump pH dosing controller.
`timescale 1ns / 1ps

//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------------
//  in      | sink      | i_in_valid / o_in_stall   | i_command, i_now_ms, i_ph_sample
//  out     | source    | o_out_valid / i_out_stall | o_up_pump_on, o_down_pump_on, o_auto_on,
//          |           |                           | o_ph_condition, o_time_left_ms
//  cfg     | APB slave | psel, penable, pready     | paddr, pwdata, prdata
//
//  One transaction per cycle while neither channel stalls; a result reaches the output through
//  the input register, then one pass of compare logic into the result register.
//  The pump state updates in the same edge that loads the result register.
//  Reset is synchronous and active low; it restores register and pump defaults.
//  A stalled result holds in the output register while one more input waits in
//  the input register; o_in_stall rises only when both are full.

module ph_dosing_controller #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [2:0]                 i_command,
    input  logic [31:0]                i_now_ms,
    input  logic [10:0]                i_ph_sample,
    // output channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_up_pump_on,
    output logic                       o_down_pump_on,
    output logic                       o_auto_on,
    output logic [1:0]                 o_ph_condition,
    output logic [21:0]                o_time_left_ms,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [phd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int unsigned CW = (TIME_WIDTH > phd_pkg::MS_W) ? TIME_WIDTH : phd_pkg::MS_W;

    // Widen an elapsed time for compares against the millisecond limits
    function automatic logic [CW-1:0] ext_t(input logic [TIME_WIDTH-1:0] v);
        logic [CW+TIME_WIDTH-1:0] w;
        w = {{CW{1'b0}}, v};
        return w[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] ext_ms(input logic [phd_pkg::MS_W-1:0] v);
        logic [CW+phd_pkg::MS_W-1:0] w;
        w = {{CW{1'b0}}, v};
        return w[CW-1:0];
    endfunction

    // Time remaining until elapsed reaches limit, zero once reached
    function automatic logic [phd_pkg::MS_W-1:0] left_of(input logic [CW-1:0] e,
                                                         input logic [phd_pkg::MS_W-1:0] lim);
        logic [phd_pkg::MS_W-1:0] r;
        if (e < ext_ms(lim)) begin
            r = lim - e[phd_pkg::MS_W-1:0];
        end else begin
            r = '0;
        end
        return r;
    endfunction

    phd_pkg::t_cfg cfg;

    phd_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    logic        r_s1_vld;
    logic [2:0]  r_s1_cmd;
    logic [31:0] r_s1_now;
    logic [10:0] r_s1_sample;
    logic        r_out_vld;
    logic        out_load;
    logic        s1_take;

    assign out_load   = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign s1_take    = !r_s1_vld || out_load;
    assign o_in_stall = !s1_take;

    // Capture the input transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_take) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take && i_in_valid) begin
            r_s1_cmd    <= i_command;
            r_s1_now    <= i_now_ms;
            r_s1_sample <= i_ph_sample;
        end
    end

    // ---------------------------------------------------------------
    // Controller state
    // ---------------------------------------------------------------
    logic                  r_up_run, r_dn_run, r_auto;
    logic [TIME_WIDTH-1:0] r_up_start, r_dn_start, r_up_stop, r_dn_stop;
    logic                  n_up_run, n_dn_run, n_auto;
    logic [TIME_WIDTH-1:0] n_up_start, n_dn_start, n_up_stop, n_dn_stop;

    // Timestamp taken modulo 2^TIME_WIDTH
    logic [TIME_WIDTH+31:0] now_w;
    logic [TIME_WIDTH-1:0]  now_t;
    assign now_w = {{TIME_WIDTH{1'b0}}, r_s1_now};
    assign now_t = now_w[TIME_WIDTH-1:0];

    // Elapsed times against every stored timestamp, all in parallel
    logic [CW-1:0] e_up_start, e_dn_start, e_up_stop, e_dn_stop;
    assign e_up_start = ext_t(now_t - r_up_start);
    assign e_dn_start = ext_t(now_t - r_dn_start);
    assign e_up_stop  = ext_t(now_t - r_up_stop);
    assign e_dn_stop  = ext_t(now_t - r_dn_stop);

    logic lim_up, lim_dn, cool_up_ok, cool_dn_ok, cool_zero;
    assign lim_up     = e_up_start >= ext_ms(cfg.dose_time_ms);
    assign lim_dn     = e_dn_start >= ext_ms(cfg.dose_time_ms);
    assign cool_up_ok = e_up_stop >= ext_ms(cfg.cooldown_ms);
    assign cool_dn_ok = e_dn_stop >= ext_ms(cfg.cooldown_ms);
    assign cool_zero  = (cfg.cooldown_ms == '0);

    // pH error and its classification
    logic signed [11:0] err, db;
    logic        [10:0] err_mag;
    logic               outside, sample_ok, want_up, want_dn;
    assign err       = $signed({1'b0, r_s1_sample}) - $signed({1'b0, cfg.target_ph});
    assign err_mag   = err[11] ? 11'(-err) : err[10:0];
    assign outside   = err_mag > cfg.tolerance;
    assign db        = $signed({1'b0, cfg.deadband});
    assign sample_ok = (r_s1_sample != '0) && (r_s1_sample <= phd_pkg::PH_VALID_MAX);
    assign want_dn   = sample_ok && outside && (err > db);
    assign want_up   = sample_ok && outside && (err < -db);

    // Flags for timestamps rewritten by this transaction
    logic up_started, dn_started, up_stopped, dn_stopped;
    logic up_after, dn_after, do_try;

    // Next state: command decode, run limit, then start decision
    always_comb begin
        n_up_run   = r_up_run;
        n_dn_run   = r_dn_run;
        n_auto     = r_auto;
        n_up_start = r_up_start;
        n_dn_start = r_dn_start;
        n_up_stop  = r_up_stop;
        n_dn_stop  = r_dn_stop;
        up_started = 1'b0;
        dn_started = 1'b0;
        up_stopped = 1'b0;
        dn_stopped = 1'b0;
        up_after   = r_up_run;
        dn_after   = r_dn_run;
        do_try     = 1'b0;

        unique case (r_s1_cmd) inside
            phd_pkg::CMD_EVAL: begin
                if (r_auto) begin
                    up_stopped = r_up_run && lim_up;
                    dn_stopped = r_dn_run && lim_dn;
                    up_after   = r_up_run && !lim_up;
                    dn_after   = r_dn_run && !lim_dn;
                    do_try     = 1'b1;
                end
            end
            phd_pkg::CMD_TOGGLE_UP: begin
                n_auto = 1'b0;
                if (r_up_run) begin
                    up_stopped = 1'b1;
                    up_after   = 1'b0;
                end else begin
                    // down pump drops without a new stop time
                    dn_after   = 1'b0;
                    up_after   = 1'b1;
                    up_started = 1'b1;
                end
            end
            phd_pkg::CMD_TOGGLE_DN: begin
                n_auto = 1'b0;
                if (r_dn_run) begin
                    dn_stopped = 1'b1;
                    dn_after   = 1'b0;
                end else begin
                    up_after   = 1'b0;
                    dn_after   = 1'b1;
                    dn_started = 1'b1;
                end
            end
            phd_pkg::CMD_STOP, phd_pkg::CMD_AUTO_OFF: begin
                n_auto     = 1'b0;
                up_stopped = r_up_run;
                dn_stopped = r_dn_run;
                up_after   = 1'b0;
                dn_after   = 1'b0;
            end
            phd_pkg::CMD_AUTO_ON: begin
                n_auto = 1'b1;
                if (r_up_run || r_dn_run) begin
                    up_stopped = r_up_run;
                    dn_stopped = r_dn_run;
                    up_after   = 1'b0;
                    dn_after   = 1'b0;
                    do_try     = 1'b1;
                end
            end
            default: ;
        endcase

        // Start a pump when none runs and its cooldown has passed
        if (do_try && !up_after && !dn_after) begin
            if (want_dn && (dn_stopped ? cool_zero : cool_dn_ok)) begin
                dn_after   = 1'b1;
                dn_started = 1'b1;
            end else if (want_up && (up_stopped ? cool_zero : cool_up_ok)) begin
                up_after   = 1'b1;
                up_started = 1'b1;
            end
        end

        n_up_run = up_after;
        n_dn_run = dn_after;
        if (up_started) n_up_start = now_t;
        if (dn_started) n_dn_start = now_t;
        if (up_stopped) n_up_stop  = now_t;
        if (dn_stopped) n_dn_stop  = now_t;
    end

    // Result fields from the updated state
    logic [1:0]               cond;
    logic [phd_pkg::MS_W-1:0] run_up_left, run_dn_left, cool_up_left, cool_dn_left;
    logic [phd_pkg::MS_W-1:0] left;

    assign run_up_left  = left_of(up_started ? '0 : e_up_start, cfg.dose_time_ms);
    assign run_dn_left  = left_of(dn_started ? '0 : e_dn_start, cfg.dose_time_ms);
    assign cool_up_left = left_of(up_stopped ? '0 : e_up_stop, cfg.cooldown_ms);
    assign cool_dn_left = left_of(dn_stopped ? '0 : e_dn_stop, cfg.cooldown_ms);

    always_comb begin
        if (!outside) begin
            cond = phd_pkg::COND_IN_RANGE;
        end else if (!err[11]) begin
            cond = phd_pkg::COND_TOO_HIGH;
        end else begin
            cond = phd_pkg::COND_TOO_LOW;
        end

        if (!n_auto) begin
            left = '0;
        end else if (n_up_run) begin
            left = run_up_left;
        end else if (n_dn_run) begin
            left = run_dn_left;
        end else begin
            left = (cool_up_left > cool_dn_left) ? cool_up_left : cool_dn_left;
        end
    end

    // Advance the pump state as the transaction moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_run   <= 1'b0;
            r_dn_run   <= 1'b0;
            r_auto     <= 1'b1;
            r_up_start <= '0;
            r_dn_start <= '0;
            r_up_stop  <= '0;
            r_dn_stop  <= '0;
        end else if (out_load) begin
            r_up_run   <= n_up_run;
            r_dn_run   <= n_dn_run;
            r_auto     <= n_auto;
            r_up_start <= n_up_start;
            r_dn_start <= n_dn_start;
            r_up_stop  <= n_up_stop;
            r_dn_stop  <= n_dn_stop;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_up_pump_on   <= n_up_run;
            o_down_pump_on <= n_dn_run;
            o_auto_on      <= n_auto;
            o_ph_condition <= cond;
            o_time_left_ms <= left;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

// ----- sv/phd_cfg_regs.sv -----
// APB configuration registers for the pH dosing controller.
`timescale 1ns / 1ps

module phd_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [phd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output phd_pkg::t_cfg              o_cfg
);

    phd_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [2:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    // Write the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_ph    <= phd_pkg::TARGET_RST;
            r_cfg.tolerance    <= phd_pkg::TOL_RST;
            r_cfg.deadband     <= phd_pkg::DEADBAND_RST;
            r_cfg.dose_time_ms <= phd_pkg::DOSE_RST;
            r_cfg.cooldown_ms  <= phd_pkg::COOLDOWN_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                phd_pkg::REG_TARGET:   r_cfg.target_ph    <= pwdata[phd_pkg::PH_W-1:0];
                phd_pkg::REG_TOL:      r_cfg.tolerance    <= pwdata[phd_pkg::PH_W-1:0];
                phd_pkg::REG_DEADBAND: r_cfg.deadband     <= pwdata[phd_pkg::PH_W-1:0];
                phd_pkg::REG_DOSE:     r_cfg.dose_time_ms <= pwdata[phd_pkg::MS_W-1:0];
                phd_pkg::REG_COOLDOWN: r_cfg.cooldown_ms  <= pwdata[phd_pkg::MS_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (reg_idx)
            phd_pkg::REG_TARGET:   prdata = {21'd0, r_cfg.target_ph};
            phd_pkg::REG_TOL:      prdata = {21'd0, r_cfg.tolerance};
            phd_pkg::REG_DEADBAND: prdata = {21'd0, r_cfg.deadband};
            phd_pkg::REG_DOSE:     prdata = {10'd0, r_cfg.dose_time_ms};
            phd_pkg::REG_COOLDOWN: prdata = {10'd0, r_cfg.cooldown_ms};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

// ----- sv/phd_checker.sv -----
// Port-level checker for the pH dosing controller, bound to the top level.
`timescale 1ns / 1ps

module phd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_up_pump_on,
    input logic        o_down_pump_on,
    input logic        o_auto_on,
    input logic [1:0]  o_ph_condition,
    input logic [21:0] o_time_left_ms
);

    // Never drive both pumps at once
    a_one_pump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_up_pump_on && o_down_pump_on))
        else $error("both pumps reported on");

    // Condition code stays within its three meanings
    a_cond_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_ph_condition == phd_pkg::COND_IN_RANGE ||
                         o_ph_condition == phd_pkg::COND_TOO_HIGH ||
                         o_ph_condition == phd_pkg::COND_TOO_LOW))
        else $error("illegal pH condition code");

    // Manual mode reports no remaining time
    a_manual_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_auto_on) |-> (o_time_left_ms == '0))
        else $error("time left reported in manual mode");

    // A stalled result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_up_pump_on) &&
            $stable(o_down_pump_on) && $stable(o_auto_on) &&
            $stable(o_ph_condition) && $stable(o_time_left_ms)))
        else $error("stalled result changed");

endmodule

bind ph_dosing_controller phd_checker u_phd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_up_pump_on   (o_up_pump_on),
    .o_down_pump_on (o_down_pump_on),
    .o_auto_on      (o_auto_on),
    .o_ph_condition (o_ph_condition),
    .o_time_left_ms (o_time_left_ms)
);
